### design/t16ieu_pkg.sv
package t16ieu_pkg;

    localparam int unsigned RegCount = 15;
    localparam logic [3:0] SpIndex = 4'd13;
    localparam logic [3:0] LrIndex = 4'd14;
    localparam logic [3:0] PcIndex = 4'd15;
    localparam logic [31:0] SpResetValue = 32'h2000_0000;

    typedef enum logic [1:0] {
        ST_EXEC   = 2'd0,
        ST_MEM    = 2'd1,
        ST_UNDEF  = 2'd2,
        ST_HALTED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        DP_AND = 4'h0, DP_EOR = 4'h1, DP_LSL = 4'h2, DP_LSR = 4'h3,
        DP_ASR = 4'h4, DP_ADC = 4'h5, DP_SBC = 4'h6, DP_ROR = 4'h7,
        DP_TST = 4'h8, DP_NEG = 4'h9, DP_CMP = 4'hA, DP_CMN = 4'hB,
        DP_ORR = 4'hC, DP_MUL = 4'hD, DP_BIC = 4'hE, DP_MVN = 4'hF
    } t_dp_op;

    typedef enum logic [1:0] {
        HI_ADD = 2'd0, HI_CMP = 2'd1, HI_MOV = 2'd2, HI_BX = 2'd3
    } t_hi_op;

    typedef enum logic [1:0] {
        IM_MOV = 2'd0, IM_CMP = 2'd1, IM_ADD = 2'd2, IM_SUB = 2'd3
    } t_imm_op;

    typedef struct packed {
        logic [31:0] r;
        logic [3:0]  nzcv;
    } t_add_res;

    typedef struct packed {
        logic [31:0] next_address;
        logic        branch_taken;
        logic        dest_written;
        logic [3:0]  dest_index;
        logic [31:0] dest_value;
        logic [3:0]  flags_nzcv;
        logic        halt_now;
        t_status     status;
        logic        bl_we;
        logic [31:0] bl_value;
    } t_exec;

    function automatic t_add_res add_flags(input logic [31:0] a, input logic [31:0] b,
                                           input logic cin);
        logic [32:0] s;
        t_add_res    res;
        s = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        res.r = s[31:0];
        res.nzcv = {s[31], (s[31:0] == 32'd0), s[32], (a[31] ^ s[31]) & (b[31] ^ s[31])};
        return res;
    endfunction

endpackage

### design/t16ieu_if.sv
interface t16ieu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] instruction;
    logic [31:0] instruction_address;
    modport source (output valid, output instruction, output instruction_address, input ready);
    modport sink (input valid, input instruction, input instruction_address, output ready);
endinterface

interface t16ieu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_address;
    logic        branch_taken;
    logic        dest_written;
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic [3:0]  flags_nzcv;
    logic        halt_now;
    logic [1:0]  status;
    modport source (output valid, output next_address, output branch_taken,
                    output dest_written, output dest_index, output dest_value,
                    output flags_nzcv, output halt_now, output status, input ready);
    modport sink (input valid, input next_address, input branch_taken,
                  input dest_written, input dest_index, input dest_value,
                  input flags_nzcv, input halt_now, input status, output ready);
endinterface

### design/t16ieu_exec.sv
module t16ieu_exec (
    input  logic [15:0]          i_ins,
    input  logic [31:0]          i_addr,
    input  logic [31:0]          i_regs [t16ieu_pkg::RegCount],
    input  logic [3:0]           i_flags,
    input  logic [31:0]          i_bl_base,
    input  logic                 i_halted,
    output t16ieu_pkg::t_exec    o_res
);
    import t16ieu_pkg::*;

    logic [31:0] pc2;
    logic [4:0]  top5;
    logic [3:0]  top4;
    logic [5:0]  top6;
    logic [31:0] va, vb, r, vs, vd;
    logic        c;
    logic [4:0]  imm5, k, km1;
    logic [7:0]  sh;
    logic [32:0] t33;
    logic [3:0]  rs4, rd4;
    logic [31:0] base, off32;
    logic [31:0] prod;
    t_add_res    ar;
    t_dp_op      dop;

    function automatic logic [31:0] rd_reg(input logic [3:0] idx, input logic [31:0] pc,
                                           input logic [31:0] regs [RegCount]);
        logic [31:0] v;
        if (idx == PcIndex) v = pc;
        else v = regs[idx];
        return v;
    endfunction

    function automatic logic cond_ok(input logic [3:0] cc, input logic [3:0] f);
        logic n, z, cf, v, ok;
        n = f[3]; z = f[2]; cf = f[1]; v = f[0];
        unique case (cc)
            4'h0: ok = z;
            4'h1: ok = !z;
            4'h2: ok = cf;
            4'h3: ok = !cf;
            4'h4: ok = n;
            4'h5: ok = !n;
            4'h6: ok = v;
            4'h7: ok = !v;
            4'h8: ok = cf && !z;
            4'h9: ok = !cf || z;
            4'hA: ok = (n == v);
            4'hB: ok = (n != v);
            4'hC: ok = !z && (n == v);
            4'hD: ok = z || (n != v);
            4'hE: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    assign pc2  = i_addr + 32'd2;
    assign top5 = i_ins[15:11];
    assign top4 = i_ins[15:12];
    assign top6 = i_ins[15:10];
    assign prod = va * vb;

    always_comb begin
        o_res = '0;
        o_res.next_address = pc2;
        o_res.flags_nzcv   = i_flags;
        o_res.halt_now     = i_halted;
        o_res.status       = ST_EXEC;
        va = '0; vb = '0; r = '0; vs = '0; vd = '0;
        c = i_flags[1];
        imm5 = i_ins[10:6];
        k = '0; km1 = '0;
        sh = '0; t33 = '0;
        rs4 = i_ins[6:3];
        rd4 = {i_ins[7], i_ins[2:0]};
        base = '0; off32 = '0;
        ar = '0;
        dop = t_dp_op'(i_ins[9:6]);

        priority if (i_halted) begin
            o_res.next_address = i_addr;
            o_res.status = ST_HALTED;
        end else if (top5 <= 5'd2) begin
            va = i_regs[{1'b0, i_ins[5:3]}];
            r = va;
            km1 = imm5 - 5'd1;
            unique case (top5[1:0])
                2'd0: begin
                    if (imm5 != 5'd0) begin
                        k = 5'd0 - imm5;
                        c = va[k];
                        r = va << imm5;
                    end
                end
                2'd1: begin
                    if (imm5 == 5'd0) begin
                        c = va[31]; r = '0;
                    end else begin
                        c = va[km1]; r = va >> imm5;
                    end
                end
                default: begin
                    if (imm5 == 5'd0) begin
                        c = va[31]; r = {32{va[31]}};
                    end else begin
                        c = va[km1]; r = 32'($signed(va) >>> imm5);
                    end
                end
            endcase
            o_res.flags_nzcv = {r[31], (r == 32'd0), c, i_flags[0]};
            o_res.dest_written = 1'b1;
            o_res.dest_index = {1'b0, i_ins[2:0]};
            o_res.dest_value = r;
        end else if (top5 == 5'd3) begin
            va = i_regs[{1'b0, i_ins[5:3]}];
            vb = i_ins[10] ? {29'd0, i_ins[8:6]} : i_regs[{1'b0, i_ins[8:6]}];
            ar = i_ins[9] ? add_flags(va, ~vb, 1'b1) : add_flags(va, vb, 1'b0);
            o_res.flags_nzcv = ar.nzcv;
            o_res.dest_written = 1'b1;
            o_res.dest_index = {1'b0, i_ins[2:0]};
            o_res.dest_value = ar.r;
        end else if (top5 <= 5'd7) begin
            va = i_regs[{1'b0, i_ins[10:8]}];
            vb = {24'd0, i_ins[7:0]};
            o_res.dest_index = {1'b0, i_ins[10:8]};
            unique case (t_imm_op'(top5[1:0]))
                IM_MOV: begin
                    o_res.flags_nzcv = {1'b0, (vb == 32'd0), i_flags[1:0]};
                    o_res.dest_written = 1'b1;
                    o_res.dest_value = vb;
                end
                IM_CMP: begin
                    ar = add_flags(va, ~vb, 1'b1);
                    o_res.flags_nzcv = ar.nzcv;
                    o_res.dest_index = '0;
                end
                IM_ADD: begin
                    ar = add_flags(va, vb, 1'b0);
                    o_res.flags_nzcv = ar.nzcv;
                    o_res.dest_written = 1'b1;
                    o_res.dest_value = ar.r;
                end
                default: begin
                    ar = add_flags(va, ~vb, 1'b1);
                    o_res.flags_nzcv = ar.nzcv;
                    o_res.dest_written = 1'b1;
                    o_res.dest_value = ar.r;
                end
            endcase
        end else if (top6 == 6'h10) begin
            va = i_regs[{1'b0, i_ins[2:0]}];
            vb = i_regs[{1'b0, i_ins[5:3]}];
            sh = vb[7:0];
            km1 = sh[4:0] - 5'd1;
            r = va;
            unique case (dop)
                DP_AND: r = va & vb;
                DP_EOR: r = va ^ vb;
                DP_LSL: begin
                    t33 = {1'b0, va} << sh[4:0];
                    if (sh != 8'd0) begin
                        if (sh < 8'd32) c = t33[32];
                        else if (sh == 8'd32) c = va[0];
                        else c = 1'b0;
                    end
                    r = (sh >= 8'd32) ? 32'd0 : t33[31:0];
                end
                DP_LSR: begin
                    if (sh != 8'd0) begin
                        if (sh < 8'd32) c = va[km1];
                        else if (sh == 8'd32) c = va[31];
                        else c = 1'b0;
                    end
                    r = (sh >= 8'd32) ? 32'd0 : (va >> sh[4:0]);
                end
                DP_ASR: begin
                    if (sh != 8'd0) c = (sh < 8'd32) ? va[km1] : va[31];
                    r = (sh >= 8'd32) ? {32{va[31]}} : 32'($signed(va) >>> sh[4:0]);
                end
                DP_ADC: ar = add_flags(va, vb, i_flags[1]);
                DP_SBC: ar = add_flags(va, ~vb, i_flags[1]);
                DP_ROR: begin
                    k = sh[4:0];
                    if (sh != 8'd0) begin
                        if (k == 5'd0) c = va[31];
                        else begin
                            c = va[km1];
                            r = (va >> k) | (va << (5'd0 - k));
                        end
                    end
                end
                DP_TST: r = va & vb;
                DP_NEG: ar = add_flags(32'd0, ~vb, 1'b1);
                DP_CMP: ar = add_flags(va, ~vb, 1'b1);
                DP_CMN: ar = add_flags(va, vb, 1'b0);
                DP_ORR: r = va | vb;
                DP_MUL: r = prod;
                DP_BIC: r = va & ~vb;
                default: r = ~vb;
            endcase
            unique case (dop)
                DP_ADC, DP_SBC, DP_NEG: begin
                    o_res.flags_nzcv = ar.nzcv;
                    o_res.dest_written = 1'b1;
                    o_res.dest_index = {1'b0, i_ins[2:0]};
                    o_res.dest_value = ar.r;
                end
                DP_CMP, DP_CMN: o_res.flags_nzcv = ar.nzcv;
                DP_TST: o_res.flags_nzcv = {r[31], (r == 32'd0), i_flags[1:0]};
                default: begin
                    o_res.flags_nzcv = {r[31], (r == 32'd0), c, i_flags[0]};
                    o_res.dest_written = 1'b1;
                    o_res.dest_index = {1'b0, i_ins[2:0]};
                    o_res.dest_value = r;
                end
            endcase
        end else if (top6 == 6'h11) begin
            vs = rd_reg(rs4, pc2, i_regs);
            vd = rd_reg(rd4, pc2, i_regs);
            unique case (t_hi_op'(i_ins[9:8]))
                HI_CMP: begin
                    ar = add_flags(vd, ~vs, 1'b1);
                    o_res.flags_nzcv = ar.nzcv;
                end
                HI_BX: begin
                    if (i_ins[7]) begin
                        o_res.dest_written = 1'b1;
                        o_res.dest_index = LrIndex;
                        o_res.dest_value = pc2 | 32'd1;
                    end
                    o_res.next_address = {vs[31:1], 1'b0};
                    o_res.branch_taken = 1'b1;
                    if (!vs[0]) o_res.halt_now = 1'b1;
                end
                default: begin
                    r = (i_ins[9:8] == HI_ADD) ? vd + vs : vs;
                    if (rd4 != PcIndex) begin
                        o_res.dest_written = 1'b1;
                        o_res.dest_index = rd4;
                        o_res.dest_value = r;
                    end else begin
                        o_res.next_address = {r[31:1], 1'b0};
                        o_res.branch_taken = 1'b1;
                    end
                end
            endcase
        end else if (top5 == 5'd9 || (top4 == 4'h5 && !i_ins[9]) || top4 == 4'h6
                     || top4 == 4'h7 || top4 == 4'h8 || top4 == 4'h9 || top4 == 4'hC) begin
            o_res.status = ST_MEM;
        end else if (top4 == 4'hA) begin
            base = i_ins[11] ? i_regs[SpIndex] : ((pc2 + 32'd2) & ~32'd3);
            o_res.dest_written = 1'b1;
            o_res.dest_index = {1'b0, i_ins[10:8]};
            o_res.dest_value = base + {22'd0, i_ins[7:0], 2'b00};
        end else if (top4 == 4'hB) begin
            // hints and breakpoint fall through as no-ops
            if (i_ins[11:8] == 4'h0) begin
                va = i_regs[SpIndex];
                vb = {23'd0, i_ins[6:0], 2'b00};
                o_res.dest_written = 1'b1;
                o_res.dest_index = SpIndex;
                o_res.dest_value = i_ins[7] ? va - vb : va + vb;
            end else if (i_ins[11:8] != 4'hF && i_ins[11:8] != 4'hE) begin
                o_res.status = ST_MEM;
            end
        end else if (top4 == 4'hD && i_ins[11:8] != 4'hF) begin
            off32 = {{23{i_ins[7]}}, i_ins[7:0], 1'b0};
            if (cond_ok(i_ins[11:8], i_flags)) begin
                o_res.next_address = pc2 + 32'd2 + off32;
                o_res.branch_taken = 1'b1;
            end
        end else if (top5 == 5'h1C) begin
            off32 = {{20{i_ins[10]}}, i_ins[10:0], 1'b0};
            o_res.next_address = pc2 + 32'd2 + off32;
            o_res.branch_taken = 1'b1;
        end else if (top5 == 5'h1E) begin
            off32 = {{10{i_ins[10]}}, i_ins[10:0], 11'd0} << 1;
            o_res.bl_we = 1'b1;
            o_res.bl_value = pc2 + 32'd2 + off32;
        end else if (top5 == 5'h1F) begin
            o_res.dest_written = 1'b1;
            o_res.dest_index = LrIndex;
            o_res.dest_value = pc2 | 32'd1;
            o_res.next_address = i_bl_base + {20'd0, i_ins[10:0], 1'b0};
            o_res.branch_taken = 1'b1;
        end else begin
            o_res.status = ST_UNDEF;
        end
    end

endmodule

### design/thumb16_integer_execute_unit.sv
// Path: an accepted item is held in the input register and then in the result register,
// where its result waits to be accepted.
// Throughput: one item per cycle while o_out.ready is high; each item decodes and
// executes in a single pass between the input register and the result register.
// Reset (synchronous, active low): registers cleared, R13 = 0x20000000, flags,
// BL base and halt cleared, both pipeline stages empty.
module thumb16_integer_execute_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    t16ieu_in_if.sink           i_in,
    t16ieu_out_if.source        o_out,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import t16ieu_pkg::*;

    logic        r_in_valid;
    logic [15:0] r_ins;
    logic [31:0] r_addr;
    logic        r_out_valid;
    t_exec       r_out;
    logic [31:0] r_regs [RegCount];
    logic [3:0]  r_flags;
    logic [31:0] r_bl_base;
    logic        r_halted;
    t_exec       n_out;
    logic        advance;

    t16ieu_exec u_exec (
        .i_ins     (r_ins),
        .i_addr    (r_addr),
        .i_regs    (r_regs),
        .i_flags   (r_flags),
        .i_bl_base (r_bl_base),
        .i_halted  (r_halted),
        .o_res     (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_ins  <= i_in.instruction;
            r_addr <= i_in.instruction_address;
        end
        if (advance) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
            r_bl_base   <= '0;
            r_halted    <= 1'b0;
            for (int i = 0; i < int'(RegCount); i++)
                r_regs[i] <= (i == int'(SpIndex)) ? SpResetValue : 32'd0;
        end else begin
            if (i_in.valid && i_in.ready) r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
            if (advance) begin
                r_flags  <= n_out.flags_nzcv;
                r_halted <= n_out.halt_now;
                if (n_out.bl_we) r_bl_base <= n_out.bl_value;
            end
            if (i_cfg_we) r_regs[SpIndex] <= i_cfg_wdata;
            else if (advance && n_out.dest_written) r_regs[n_out.dest_index] <= n_out.dest_value;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.next_address = r_out.next_address;
    assign o_out.branch_taken = r_out.branch_taken;
    assign o_out.dest_written = r_out.dest_written;
    assign o_out.dest_index   = r_out.dest_index;
    assign o_out.dest_value   = r_out.dest_value;
    assign o_out.flags_nzcv   = r_out.flags_nzcv;
    assign o_out.halt_now     = r_out.halt_now;
    assign o_out.status       = r_out.status;

endmodule
